// ===== hw/rtl/mcr_pkg.sv =====
// mcr_pkg: shared types and constants of the merge chain resolver
// used by merge_chain_resolver_core and its port checker; no dependencies
`default_nettype none

package mcr_pkg;

   // default store depth and key width
   localparam int MAX_PAIRS_DEF = 256;
   localparam int KEY_BITS_DEF  = 32;

   // field widths of the stream channels
   localparam int OP_BITS     = 2;
   localparam int IN_KEY_BITS = 32;
   localparam int IDX_BITS    = 8;
   localparam int CNT_BITS    = 9;
   localparam int REQ_BITS    = 72;
   localparam int RSP_BITS    = 24;

   // command codes carried in tuser
   typedef enum logic [OP_BITS-1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_RESOLVE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/merge_chain_resolver_core.sv =====
// merge_chain_resolver_core: pair store, base-key id table and link resolver
// depends on mcr_pkg
`default_nettype none

// One command per transaction, one response per command. Clear goes straight
// to the response register, as do a refused read and a dropped append; a good
// read fetches the pair base id and then its link, and an append searches the ids.
// Resolve first links every id to itself, then visits each pair; a pair whose base
// is still self-linked adds a key search over the ids, follows links and ends the
// walk by writing the link.
// All of it runs through a single sequencer over four
// single-port memories (pair base id, pair target key, distinct key, link),
// one registered read each per cycle; the id search is linear.
// req_tready is high only while the sequencer is idle; a finished response
// sits in the output register so the next command can be taken meanwhile.
module merge_chain_resolver_core #(
   parameter int MAX_PAIRS = mcr_pkg::MAX_PAIRS_DEF,
   parameter int KEY_BITS  = mcr_pkg::KEY_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   // base_key[31:0], target_key[63:32], pair_index[71:64]
   input  wire  [mcr_pkg::REQ_BITS-1:0]  req_tdata,
   // opcode[1:0]
   input  wire  [mcr_pkg::OP_BITS-1:0]   req_tuser,
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   // status[1:0], filtered[2], pairs_held[11:3], distinct_bases[20:12], zero[23:21]
   output logic [mcr_pkg::RSP_BITS-1:0]  rsp_tdata
);
   import mcr_pkg::*;

   localparam int IDW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CW  = $clog2(MAX_PAIRS + 1);
   localparam int KW  = (KEY_BITS < IN_KEY_BITS) ? KEY_BITS : IN_KEY_BITS;
   localparam int IW  = (CW > IDX_BITS) ? CW : IDX_BITS;
   localparam logic [CW-1:0] NONE = CW'(MAX_PAIRS);

   typedef enum logic [3:0] {
      S_IDLE, S_F_RD, S_F_CMP, S_APP_WR, S_R_INIT, S_R_PRD, S_R_PGET,
      S_R_BCHK, S_R_WALK, S_R_WCHK, S_R_WR, S_RD_PAIR, S_RD_LINK, S_RD_CMP,
      S_RESP
   } state_type;

   // memories
   logic [IDW-1:0] pb_mem [MAX_PAIRS];
   logic [KW-1:0]  pt_mem [MAX_PAIRS];
   logic [KW-1:0]  dk_mem [MAX_PAIRS];
   logic [CW-1:0]  lk_mem [MAX_PAIRS];
   logic [IDW-1:0] pb_rd_ff;
   logic [KW-1:0]  pt_rd_ff, dk_rd_ff;
   logic [CW-1:0]  lk_rd_ff;

   logic           pb_we, pt_we, dk_we, lk_we;
   logic [IDW-1:0] pb_addr, dk_addr, lk_addr;
   logic [IDW-1:0] pb_wd;
   logic [CW-1:0]  lk_wd;

   // registers
   state_type      state_ff, state_in;
   op_type         op_ff, op_in;
   logic [KW-1:0]  bkey_ff, bkey_in, tkey_ff, tkey_in, fkey_ff, fkey_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  pc_ff, pc_in, ids_ff, ids_in;
   logic           res_ff, res_in;
   logic [CW-1:0]  scan_ff, scan_in, p_ff, p_in, t_ff, t_in;
   logic [IDW-1:0] b_ff, b_in;
   status_type     st_ff, st_in;
   logic           filt_ff, filt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [CW-1:0]  scan_nx;
   logic [CW-1:0]  b_ext;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign scan_nx    = CW'(scan_ff + 1'b1);
   assign b_ext      = CW'(b_ff);

   // sequencer next state and memory controls
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      bkey_in = bkey_ff;
      tkey_in = tkey_ff;
      fkey_in = fkey_ff;
      idx_in = idx_ff;
      pc_in = pc_ff;
      ids_in = ids_ff;
      res_in = res_ff;
      scan_in = scan_ff;
      p_in = p_ff;
      t_in = t_ff;
      b_in = b_ff;
      st_in = st_ff;
      filt_in = filt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      pb_we = 1'b0;
      pt_we = 1'b0;
      dk_we = 1'b0;
      lk_we = 1'b0;
      pb_addr = p_ff[IDW-1:0];
      dk_addr = scan_ff[IDW-1:0];
      lk_addr = b_ff;
      pb_wd = '0;
      lk_wd = t_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = op_type'(req_tuser);
               bkey_in = req_tdata[KW-1:0];
               tkey_in = req_tdata[IN_KEY_BITS +: KW];
               idx_in = IW'(req_tdata[2*IN_KEY_BITS +: IDX_BITS]);
               st_in = ST_OK;
               filt_in = 1'b0;
               scan_in = '0;
               p_in = '0;
               unique case (op_type'(req_tuser))
                  OP_CLEAR: begin
                     pc_in = '0;
                     ids_in = '0;
                     res_in = 1'b0;
                     state_in = S_RESP;
                  end
                  OP_APPEND: begin
                     fkey_in = req_tdata[KW-1:0];
                     t_in = NONE;
                     if (pc_ff == NONE) begin
                        st_in = ST_FULL;
                        state_in = S_RESP;
                     end else if (ids_ff == '0) begin
                        state_in = S_APP_WR;
                     end else begin
                        state_in = S_F_RD;
                     end
                  end
                  OP_RESOLVE: begin
                     state_in = (ids_ff == '0) ? S_R_PRD : S_R_INIT;
                  end
                  OP_READ: begin
                     if (!res_ff ||
                         IW'(req_tdata[2*IN_KEY_BITS +: IDX_BITS]) >= IW'(pc_ff)) begin
                        st_in = ST_BAD;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_RD_PAIR;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         // linear search of the distinct keys, shared by append and resolve
         S_F_RD: begin
            dk_addr = scan_ff[IDW-1:0];
            state_in = S_F_CMP;
         end
         S_F_CMP: begin
            if (dk_rd_ff == fkey_ff) begin
               t_in = scan_ff;
               state_in = (op_ff == OP_APPEND) ? S_APP_WR : S_R_WALK;
            end else if (scan_nx == ids_ff) begin
               t_in = NONE;
               state_in = (op_ff == OP_APPEND) ? S_APP_WR : S_R_WALK;
            end else begin
               scan_in = scan_nx;
               state_in = S_F_RD;
            end
         end
         // store the pair, adding a new id when the base key is new
         S_APP_WR: begin
            pb_addr = pc_ff[IDW-1:0];
            pb_we = 1'b1;
            pt_we = 1'b1;
            if (t_ff == NONE) begin
               dk_addr = ids_ff[IDW-1:0];
               dk_we = 1'b1;
               pb_wd = ids_ff[IDW-1:0];
               ids_in = CW'(ids_ff + 1'b1);
            end else begin
               pb_wd = t_ff[IDW-1:0];
            end
            pc_in = CW'(pc_ff + 1'b1);
            res_in = 1'b0;
            state_in = S_RESP;
         end
         // every id links to itself
         S_R_INIT: begin
            lk_addr = scan_ff[IDW-1:0];
            lk_wd = scan_ff;
            lk_we = 1'b1;
            if (scan_nx == ids_ff) begin
               state_in = S_R_PRD;
            end else begin
               scan_in = scan_nx;
            end
         end
         // walk the pairs in order
         S_R_PRD: begin
            pb_addr = p_ff[IDW-1:0];
            if (p_ff == pc_ff) begin
               res_in = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_R_PGET;
            end
         end
         S_R_PGET: begin
            b_in = pb_rd_ff;
            fkey_in = pt_rd_ff;
            lk_addr = pb_rd_ff;
            state_in = S_R_BCHK;
         end
         S_R_BCHK: begin
            scan_in = '0;
            if (lk_rd_ff != b_ext) begin
               p_in = CW'(p_ff + 1'b1);
               state_in = S_R_PRD;
            end else begin
               state_in = S_F_RD;
            end
         end
         // follow links until none, the base or a self-linked id
         S_R_WALK: begin
            lk_addr = t_ff[IDW-1:0];
            if (t_ff == NONE || t_ff == b_ext) begin
               state_in = S_R_WR;
            end else begin
               state_in = S_R_WCHK;
            end
         end
         S_R_WCHK: begin
            if (lk_rd_ff == t_ff) begin
               state_in = S_R_WR;
            end else begin
               t_in = lk_rd_ff;
               state_in = S_R_WALK;
            end
         end
         S_R_WR: begin
            lk_addr = b_ff;
            lk_wd = t_ff;
            lk_we = 1'b1;
            p_in = CW'(p_ff + 1'b1);
            state_in = S_R_PRD;
         end
         // read command: pair base id, then its link
         S_RD_PAIR: begin
            pb_addr = idx_ff[IDW-1:0];
            state_in = S_RD_LINK;
         end
         S_RD_LINK: begin
            b_in = pb_rd_ff;
            lk_addr = pb_rd_ff;
            state_in = S_RD_CMP;
         end
         S_RD_CMP: begin
            filt_in = (lk_rd_ff != b_ext);
            state_in = S_RESP;
         end
         // load the response register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {3'b000, CNT_BITS'(ids_ff), CNT_BITS'(pc_ff), filt_ff, st_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= '0;
         ids_ff <= '0;
         res_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         ids_ff <= ids_in;
         res_ff <= res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      bkey_ff <= bkey_in;
      tkey_ff <= tkey_in;
      fkey_ff <= fkey_in;
      idx_ff <= idx_in;
      scan_ff <= scan_in;
      p_ff <= p_in;
      t_ff <= t_in;
      b_ff <= b_in;
      st_ff <= st_in;
      filt_ff <= filt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // pair memories share the pair address
   always_ff @(posedge clock) begin
      if (pb_we) begin
         pb_mem[pb_addr] <= pb_wd;
      end
      if (pt_we) begin
         pt_mem[pb_addr] <= tkey_ff;
      end
      pb_rd_ff <= pb_mem[pb_addr];
      pt_rd_ff <= pt_mem[pb_addr];
   end

   // distinct key memory
   always_ff @(posedge clock) begin
      if (dk_we) begin
         dk_mem[dk_addr] <= bkey_ff;
      end
      dk_rd_ff <= dk_mem[dk_addr];
   end

   // link memory
   always_ff @(posedge clock) begin
      if (lk_we) begin
         lk_mem[lk_addr] <= lk_wd;
      end
      lk_rd_ff <= lk_mem[lk_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mcr_port_checker.sv =====
// mcr_port_checker: port-level assertions for merge_chain_resolver_core
// depends on mcr_pkg; bound to merge_chain_resolver_core at the end of this file
`default_nettype none

module mcr_port_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_tvalid,
   input wire                          req_tready,
   input wire                          rsp_tvalid,
   input wire                          rsp_tready,
   input wire [mcr_pkg::RSP_BITS-1:0]  rsp_tdata
);
   import mcr_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // status is one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == ST_OK || rsp_tdata[1:0] == ST_FULL ||
                      rsp_tdata[1:0] == ST_BAD))
      else $error("undefined status code");

   // filtered only on a good response
   a_filt_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_OK |-> !rsp_tdata[2])
      else $error("filtered set on a failed transaction");

   // ready drops after an accepted command
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after an accepted transaction");

endmodule

bind merge_chain_resolver_core mcr_port_checker u_mcr_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== dv/tb_merge_chain_resolver_core.sv =====
// tb_merge_chain_resolver_core: self-checking testbench of the merge chain resolver
// depends on mcr_pkg and merge_chain_resolver_core; a scoreboard class predicts responses
`default_nettype none

// scoreboard: own copy of the pair store, id table and links, plus pending responses
class resolver_scoreboard;
   localparam int DEPTH = mcr_pkg::MAX_PAIRS_DEF;
   localparam int NONE  = DEPTH;

   int unsigned      base_id_of_pair [DEPTH];
   bit [31:0]        target_of_pair  [DEPTH];
   bit [31:0]        key_of_id       [DEPTH];
   int unsigned      link_of_id      [DEPTH];
   int unsigned      n_pairs;
   int unsigned      n_ids;
   bit               is_resolved;
   bit [23:0]        pending_rsp [$];
   int unsigned      n_errors;
   int unsigned      n_checked;

   function new();
      n_pairs = 0;
      n_ids = 0;
      is_resolved = 0;
      n_errors = 0;
      n_checked = 0;
   endfunction

   function int unsigned lookup_id(bit [31:0] key);
      for (int unsigned i = 0; i < n_ids; i++)
         if (key_of_id[i] == key) return i;
      return NONE;
   endfunction

   // rebuild every link from the stored pairs
   function void resolve_links();
      int unsigned b;
      int unsigned t;
      int unsigned steps;
      for (int unsigned i = 0; i < n_ids; i++) link_of_id[i] = i;
      for (int unsigned p = 0; p < n_pairs; p++) begin
         b = base_id_of_pair[p];
         if (link_of_id[b] != b) continue;
         t = lookup_id(target_of_pair[p]);
         steps = 0;
         while (t < DEPTH && t != b && link_of_id[t] != t && steps < DEPTH) begin
            t = link_of_id[t];
            steps++;
         end
         link_of_id[b] = t;
      end
      is_resolved = 1;
   endfunction

   // note an accepted command and queue its response
   function void note_command(mcr_pkg::op_type op, bit [31:0] bkey, bit [31:0] tkey,
                              bit [7:0] idx);
      mcr_pkg::status_type st;
      bit                  filt;
      int unsigned         id;
      bit [23:0]           rsp_word;
      st = mcr_pkg::ST_OK;
      filt = 0;
      case (op)
         mcr_pkg::OP_CLEAR: begin
            n_pairs = 0;
            n_ids = 0;
            is_resolved = 0;
         end
         mcr_pkg::OP_APPEND: begin
            if (n_pairs >= DEPTH) st = mcr_pkg::ST_FULL;
            else begin
               id = lookup_id(bkey);
               if (id == NONE) begin
                  id = n_ids;
                  key_of_id[id] = bkey;
                  n_ids++;
               end
               base_id_of_pair[n_pairs] = id;
               target_of_pair[n_pairs] = tkey;
               n_pairs++;
               is_resolved = 0;
            end
         end
         mcr_pkg::OP_RESOLVE: resolve_links();
         default: begin
            if (!is_resolved || idx >= n_pairs) st = mcr_pkg::ST_BAD;
            else filt = link_of_id[base_id_of_pair[idx]] != base_id_of_pair[idx];
         end
      endcase
      rsp_word = {3'b000, n_ids[8:0], n_pairs[8:0], filt, st};
      pending_rsp = {pending_rsp, rsp_word};
   endfunction

   // compare one response with the oldest expectation
   function void check_response(bit [23:0] got);
      bit [23:0] want;
      if (pending_rsp.size() == 0) begin
         $error("response %h with none expected", got);
         n_errors++;
         return;
      end
      want = pending_rsp.pop_front();
      n_checked++;
      if (got[1:0] != want[1:0]) begin
         $error("status: expected %0d actual %0d", want[1:0], got[1:0]);
         n_errors++;
      end
      if (got[2] != want[2]) begin
         $error("filtered: expected %0d actual %0d", want[2], got[2]);
         n_errors++;
      end
      if (got[11:3] != want[11:3]) begin
         $error("pairs_held: expected %0d actual %0d", want[11:3], got[11:3]);
         n_errors++;
      end
      if (got[20:12] != want[20:12]) begin
         $error("distinct_bases: expected %0d actual %0d", want[20:12], got[20:12]);
         n_errors++;
      end
      if (got[23:21] != 3'b000) begin
         $error("padding: expected 0 actual %0d", got[23:21]);
         n_errors++;
      end
   endfunction
endclass

module tb_merge_chain_resolver_core;
   timeunit 1ns;
   timeprecision 1ps;
   import mcr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000000;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_BITS-1:0]  req_tdata;
   logic [OP_BITS-1:0]   req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_BITS-1:0]  rsp_tdata;

   resolver_scoreboard   chain_sb;
   int unsigned          idle_pct;
   int unsigned          idle_cycles;
   int unsigned          n_sent;
   bit [31:0]            key_pool [8];

   merge_chain_resolver_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns clock
   initial clock = 0;
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial chain_sb = new();

   // accepted transactions on both channels go to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            chain_sb.note_command(op_type'(req_tuser), req_tdata[31:0], req_tdata[63:32],
                                  req_tdata[71:64]);
         if (rsp_tvalid && rsp_tready) chain_sb.check_response(rsp_tdata);
      end
   end

   // response side stalls at random
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   // watchdog over cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("merge_chain_resolver_core regression: fail");
         $finish;
      end
   end

   // drive one command and wait for its acceptance
   task automatic send_command(op_type op, bit [31:0] bkey, bit [31:0] tkey, bit [7:0] idx);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {idx, tkey, bkey};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
   endtask

   task automatic release_bus();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // key drawn mostly from a small pool so that chains form
   function automatic bit [31:0] pick_key();
      return ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : $urandom();
   endfunction

   // well-formed burst: clear, appends, resolve, reads
   task automatic run_burst(int unsigned n_app);
      send_command(OP_CLEAR, $urandom(), $urandom(), 8'($urandom()));
      for (int unsigned i = 0; i < n_app; i++)
         send_command(OP_APPEND, pick_key(), pick_key(), 8'($urandom()));
      send_command(OP_RESOLVE, $urandom(), $urandom(), 8'($urandom()));
      for (int unsigned i = 0; i < n_app / 2 + 1; i++)
         send_command(OP_READ, $urandom(), $urandom(), 8'($urandom_range(n_app)));
   endtask

   initial begin
      int unsigned wait_cycles;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_CLEAR;
      idle_pct   = 36;
      n_sent     = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: read before resolve, empty resolve, extreme keys, a chain
      send_command(OP_READ, 0, 0, 8'd0);
      send_command(OP_RESOLVE, 0, 0, 8'd0);
      send_command(OP_READ, 0, 0, 8'd0);
      send_command(OP_APPEND, 32'h0000_0000, 32'hFFFF_FFFF, 8'd0);
      send_command(OP_APPEND, 32'hFFFF_FFFF, 32'h0000_0001, 8'd0);
      send_command(OP_APPEND, 32'h0000_0001, 32'h0000_0000, 8'd0);
      send_command(OP_APPEND, 32'h0000_0001, 32'h1234_5678, 8'd255);
      send_command(OP_APPEND, 32'h0000_0002, 32'h0000_0002, 8'd0);
      send_command(OP_READ, 0, 0, 8'd0);
      send_command(OP_RESOLVE, 0, 0, 8'd0);
      for (int i = 0; i < 6; i++) send_command(OP_READ, 0, 0, i[7:0]);
      send_command(OP_READ, 0, 0, 8'd255);
      send_command(OP_APPEND, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'd0);
      send_command(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1);

      // fill the store to the top, then overflow it
      send_command(OP_CLEAR, 0, 0, 8'd0);
      for (int i = 0; i < 258; i++)
         send_command(OP_APPEND, (i % 3 == 0) ? 32'(i) : 32'(i / 2), 32'(i + 1), 8'd0);
      send_command(OP_RESOLVE, 0, 0, 8'd0);
      send_command(OP_READ, 0, 0, 8'd255);

      // random bursts, the first stretch without idling
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      idle_pct = 0;
      run_burst(12);
      idle_pct = 36;
      while (n_sent < 500) begin
         if ($urandom_range(9) < 8) run_burst($urandom_range(1, 16));
         else send_command(op_type'($urandom_range(3)), pick_key(), pick_key(),
                           8'($urandom()));
         if ($urandom_range(9) == 0) key_pool[$urandom_range(7)] = $urandom();
      end
      release_bus();

      // drain outstanding responses
      wait_cycles = 0;
      while (chain_sb.pending_rsp.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      $display("covered %0d commands: clear, append up to a full store, resolve over chains,",
               n_sent);
      $display("reads in and out of range; %0d responses checked", chain_sb.n_checked);
      if (chain_sb.n_errors == 0 && chain_sb.pending_rsp.size() == 0)
         $display("merge_chain_resolver_core regression: pass");
      else
         $display("merge_chain_resolver_core regression: fail");
      $finish;
   end
endmodule

`default_nettype wire
